[rtl/mavc_pkg.sv]
`timescale 1ns / 1ps
package mavc_pkg;

    localparam int MAX_DISKS_DEF = 64;
    localparam int FLD_W         = 32;
    localparam int WORD_W        = 4 * FLD_W;
    localparam int CHUNK_W       = 16;
    localparam int QUO_W         = 48;
    localparam int QCNT_W        = $clog2(QUO_W + 1);
    localparam int ANG_W         = 32;
    localparam int USED_W        = 7;

    localparam logic [QUO_W-1:0] SAT48_MAX = {1'b0, {(QUO_W-1){1'b1}}};
    localparam logic [QUO_W-1:0] SAT48_MIN = {1'b1, {(QUO_W-1){1'b0}}};

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_NP,
        ST_RSUB,
        ST_MAG,
        ST_MAC,
        ST_DRAIN,
        ST_DIVGO,
        ST_DIVW,
        ST_ACC,
        ST_FDIV,
        ST_FWAIT
    } t_state;

    typedef struct packed {
        logic             valid;
        logic [ANG_W-1:0] angular;
        logic             zero_seen;
    } t_res;

endpackage

[rtl/mean_angular_velocity_about_centroid.sv]
`timescale 1ns / 1ps
// Mean angular velocity of a set of disks about their center of mass, Q16.16.
// Each start request loads one disk (busy stays low); the
// request with i_last_disk high closes the set and raises busy for the compute
// pass. Per stored disk the pass does a memory read, setup steps that scale
// by the count, subtract the sums and take magnitudes, a 16-bit chunked
// multiply-accumulate for the cross and squared terms, and a 48-step
// bit-serial divider that dominates. A disk at the centroid skips the multiply
// and the divide. The final division by the disk count runs on the same
// divider. The result appears for one cycle with o_valid and cannot be held
// off; busy drops in that same cycle. Disks beyond MAX_DISKS are dropped and
// flagged; the set still closes on a dropped last disk.
module mean_angular_velocity_about_centroid
    import mavc_pkg::*;
#(
    parameter int MAX_DISKS = MAX_DISKS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    input  logic signed [FLD_W-1:0] i_position_x,
    input  logic signed [FLD_W-1:0] i_position_y,
    input  logic signed [FLD_W-1:0] i_velocity_x,
    input  logic signed [FLD_W-1:0] i_velocity_y,
    input  logic                    i_last_disk,
    output logic                    busy,
    output logic                    o_valid,
    output logic signed [ANG_W-1:0] o_angular_velocity,
    output logic [USED_W-1:0]       o_disks_used,
    output logic                    o_capacity_overflow,
    output logic                    o_zero_radius_seen
);

    localparam int CW  = $clog2(MAX_DISKS + 1);
    localparam int AW  = $clog2(MAX_DISKS);
    localparam int SW  = FLD_W + CW;
    localparam int DW  = 2 * (FLD_W + CW) + 1;
    localparam int UXW = CW + USED_W;

    logic                 r_busy;
    logic                 r_go;
    logic [CW-1:0]        r_count;
    logic                 r_ovf;
    logic signed [SW-1:0] r_sum [4];
    logic                 r_valid;
    logic [ANG_W-1:0]     r_ang;
    logic [USED_W-1:0]    r_used;
    logic                 r_ovf_out;
    logic                 r_zero_out;

    logic                 w_acc;
    logic                 w_room;
    logic [UXW-1:0]       w_used;
    logic [AW-1:0]        w_raddr;
    logic [WORD_W-1:0]    w_rdata;
    logic                 w_div_start;
    logic [DW-1:0]        w_div_rem0;
    logic [QUO_W-1:0]     w_div_low;
    logic [DW-1:0]        w_div_den;
    logic                 w_div_done;
    logic [QUO_W-1:0]     w_div_quo;
    logic                 w_div_sat;
    t_res                 w_res;

    assign w_acc  = start && !r_busy;
    assign w_room = r_count < CW'(MAX_DISKS);
    assign w_used = UXW'(r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_go    <= 1'b0;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_valid <= 1'b0;
            for (int j = 0; j < 4; j++) begin
                r_sum[j] <= '0;
            end
        end else begin
            r_go    <= 1'b0;
            r_valid <= w_res.valid;
            if (w_res.valid) begin
                // release the set and get ready for the next one
                r_busy  <= 1'b0;
                r_count <= '0;
                r_ovf   <= 1'b0;
                for (int j = 0; j < 4; j++) begin
                    r_sum[j] <= '0;
                end
            end else if (w_acc) begin
                if (w_room) begin
                    r_count  <= r_count + 1'b1;
                    r_sum[0] <= r_sum[0] + SW'(i_position_x);
                    r_sum[1] <= r_sum[1] + SW'(i_position_y);
                    r_sum[2] <= r_sum[2] + SW'(i_velocity_x);
                    r_sum[3] <= r_sum[3] + SW'(i_velocity_y);
                end else begin
                    r_ovf <= 1'b1;
                end
                if (i_last_disk) begin
                    r_busy <= 1'b1;
                    r_go   <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res.valid) begin
            r_ang      <= w_res.angular;
            r_used     <= w_used[USED_W-1:0];
            r_ovf_out  <= r_ovf;
            r_zero_out <= w_res.zero_seen;
        end
    end

    mavc_store #(
        .DEPTH (MAX_DISKS),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_acc && w_room),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata ({i_position_x, i_position_y, i_velocity_x, i_velocity_y}),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    mavc_div #(
        .DW (DW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_rem0  (w_div_rem0),
        .i_low   (w_div_low),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo),
        .o_sat   (w_div_sat)
    );

    mavc_core #(
        .CW        (CW),
        .AW        (AW),
        .SW        (SW),
        .DW        (DW)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (r_go),
        .i_count     (r_count),
        .i_sum       (r_sum),
        .o_raddr     (w_raddr),
        .i_rdata     (w_rdata),
        .o_div_start (w_div_start),
        .o_div_rem0  (w_div_rem0),
        .o_div_low   (w_div_low),
        .o_div_den   (w_div_den),
        .i_div_done  (w_div_done),
        .i_div_quo   (w_div_quo),
        .i_div_sat   (w_div_sat),
        .o_res       (w_res)
    );

    assign busy                = r_busy;
    assign o_valid             = r_valid;
    assign o_angular_velocity  = r_ang;
    assign o_disks_used        = r_used;
    assign o_capacity_overflow = r_ovf_out;
    assign o_zero_radius_seen  = r_zero_out;

endmodule

[rtl/mavc_store.sv]
`timescale 1ns / 1ps
module mavc_store
    import mavc_pkg::*;
#(
    parameter int DEPTH = MAX_DISKS_DEF,
    parameter int AW    = $clog2(MAX_DISKS_DEF)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [WORD_W-1:0] i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output logic [WORD_W-1:0] o_rdata
);

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/mavc_div.sv]
`timescale 1ns / 1ps
module mavc_div
    import mavc_pkg::*;
#(
    parameter int DW = 79
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DW-1:0]    i_rem0,
    input  logic [QUO_W-1:0] i_low,
    input  logic [DW-1:0]    i_den,
    output logic             o_done,
    output logic [QUO_W-1:0] o_quo,
    output logic             o_sat
);

    logic              r_busy;
    logic              r_done;
    logic [QCNT_W-1:0] r_cnt;
    logic [DW-1:0]     r_rem;
    logic [DW-1:0]     r_den;
    logic [QUO_W-1:0]  r_low;
    logic [QUO_W-1:0]  r_q;
    logic              r_sat;

    logic [DW:0]       w_t;
    logic              w_ge;
    logic [DW:0]       w_sub;
    logic              w_big;

    assign w_t   = {r_rem, r_low[QUO_W-1]};
    assign w_ge  = w_t >= {1'b0, r_den};
    assign w_sub = w_t - {1'b0, r_den};
    // quotient would need more than QUO_W bits
    assign w_big = i_rem0 >= i_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= QCNT_W'(QUO_W);
                if (w_big) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == QCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
            r_rem <= i_rem0;
            r_low <= i_low;
            r_q   <= '0;
            r_sat <= w_big;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_sub[DW-1:0] : w_t[DW-1:0];
            r_q   <= {r_q[QUO_W-2:0], w_ge};
            r_low <= {r_low[QUO_W-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;
    assign o_sat  = r_sat;

endmodule

[rtl/mavc_core.sv]
`timescale 1ns / 1ps
module mavc_core
    import mavc_pkg::*;
#(
    parameter int CW        = $clog2(MAX_DISKS_DEF + 1),
    parameter int AW        = $clog2(MAX_DISKS_DEF),
    parameter int SW        = FLD_W + CW,
    parameter int DW        = 2 * (FLD_W + CW) + 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_go,
    input  logic [CW-1:0]        i_count,
    input  logic signed [SW-1:0] i_sum [4],
    output logic [AW-1:0]        o_raddr,
    input  logic [WORD_W-1:0]    i_rdata,
    output logic                 o_div_start,
    output logic [DW-1:0]        o_div_rem0,
    output logic [QUO_W-1:0]     o_div_low,
    output logic [DW-1:0]        o_div_den,
    input  logic                 i_div_done,
    input  logic [QUO_W-1:0]     i_div_quo,
    input  logic                 i_div_sat,
    output t_res                 o_res
);

    localparam int RW  = FLD_W + 1 + CW;
    localparam int MW  = FLD_W + CW;
    localparam int NAW = DW + 1;
    localparam int PW  = MW + CHUNK_W;
    localparam int NCH = (MW + CHUNK_W - 1) / CHUNK_W;
    localparam int KW  = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int BPW = NCH * CHUNK_W;

    t_state                r_state, n_state;
    logic [CW-1:0]         r_idx;
    logic                  r_zero;
    logic signed [RW-1:0]  r_np [4];
    logic signed [RW-1:0]  r_r [4];
    logic [MW-1:0]         r_mag [4];
    logic                  r_neg [4];
    logic [1:0]            r_pair;
    logic [KW-1:0]         r_k;
    logic [PW-1:0]         r_prod;
    logic [KW-1:0]         r_prod_k;
    logic                  r_prod_num;
    logic                  r_prod_sub;
    logic                  r_prod_v;
    logic [DW-1:0]         r_den;
    logic [NAW-1:0]        r_num;
    logic [QUO_W-1:0]      r_ang;
    t_res                  r_res;

    logic signed [CW:0]    w_n;
    logic signed [FLD_W-1:0] w_fld [4];
    logic signed [RW-1:0]  w_abs [4];
    logic                  w_last_idx;
    logic                  w_last_step;
    logic                  w_is_zero;
    logic [MW-1:0]         w_a;
    logic [MW-1:0]         w_b;
    logic                  w_num_sel;
    logic                  w_sub_sel;
    logic [BPW-1:0]        w_bpad;
    logic [CHUNK_W-1:0]    w_chunk;
    logic [NAW-1:0]        w_shift;
    logic [NAW-1:0]        w_num_abs;
    logic [DW-1:0]         w_nmag;
    logic [QUO_W-1:0]      w_ang_abs;
    logic [QUO_W-1:0]      w_term;
    logic [QUO_W:0]        w_asum;
    logic [QUO_W-1:0]      w_ang_next;
    logic [QUO_W-1:0]      w_q;
    logic [ANG_W-1:0]      w_mean;

    assign w_n = $signed({1'b0, i_count});
    assign w_fld[0] = i_rdata[4*FLD_W-1:3*FLD_W];
    assign w_fld[1] = i_rdata[3*FLD_W-1:2*FLD_W];
    assign w_fld[2] = i_rdata[2*FLD_W-1:FLD_W];
    assign w_fld[3] = i_rdata[FLD_W-1:0];

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            w_abs[j] = r_r[j][RW-1] ? -r_r[j] : r_r[j];
        end
    end

    assign w_last_idx  = r_idx == i_count - 1'b1;
    assign w_last_step = (r_pair == 2'd3) && (r_k == KW'(NCH - 1));
    assign w_is_zero   = (r_r[0] == '0) && (r_r[1] == '0);
    assign o_raddr     = r_idx[AW-1:0];

    // den = |R1|^2 + |R2|^2, num = R1*V2 - R2*V1
    always_comb begin
        case (r_pair)
            2'd0: begin
                w_a = r_mag[0]; w_b = r_mag[0]; w_num_sel = 1'b0; w_sub_sel = 1'b0;
            end
            2'd1: begin
                w_a = r_mag[1]; w_b = r_mag[1]; w_num_sel = 1'b0; w_sub_sel = 1'b0;
            end
            2'd2: begin
                w_a = r_mag[0]; w_b = r_mag[3]; w_num_sel = 1'b1;
                w_sub_sel = r_neg[0] ^ r_neg[3];
            end
            default: begin
                w_a = r_mag[1]; w_b = r_mag[2]; w_num_sel = 1'b1;
                w_sub_sel = ~(r_neg[1] ^ r_neg[2]);
            end
        endcase
    end

    assign w_bpad  = BPW'(w_b);
    assign w_chunk = w_bpad[r_k*CHUNK_W +: CHUNK_W];
    assign w_shift = NAW'(r_prod) << (CHUNK_W * r_prod_k);

    assign w_num_abs = r_num[NAW-1] ? -r_num : r_num;
    assign w_nmag    = w_num_abs[DW-1:0];
    assign w_ang_abs = r_ang[QUO_W-1] ? -r_ang : r_ang;

    // clamp each term to the signed 48-bit range
    always_comb begin
        if (!r_num[NAW-1]) begin
            w_term = (i_div_sat || i_div_quo[QUO_W-1]) ? SAT48_MAX : i_div_quo;
        end else begin
            w_term = (i_div_sat || (i_div_quo[QUO_W-1] && (i_div_quo[QUO_W-2:0] != '0)))
                   ? SAT48_MIN : -i_div_quo;
        end
    end

    assign w_asum = {r_ang[QUO_W-1], r_ang} + {w_term[QUO_W-1], w_term};
    assign w_ang_next = (w_asum[QUO_W] != w_asum[QUO_W-1])
                      ? (w_asum[QUO_W] ? SAT48_MIN : SAT48_MAX)
                      : w_asum[QUO_W-1:0];

    assign w_q = r_ang[QUO_W-1] ? -i_div_quo : i_div_quo;
    always_comb begin
        if (w_q[QUO_W-1:ANG_W-1] == '0 || w_q[QUO_W-1:ANG_W-1] == '1) begin
            w_mean = w_q[ANG_W-1:0];
        end else begin
            w_mean = w_q[QUO_W-1] ? {1'b1, {(ANG_W-1){1'b0}}} : {1'b0, {(ANG_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_prod_v <= 1'b0;
            r_res    <= '0;
        end else begin
            r_state     <= n_state;
            r_prod_v    <= r_state == ST_MAC;
            r_res.valid <= (r_state == ST_FWAIT) && i_div_done;
            if (r_state == ST_FWAIT) begin
                r_res.angular   <= w_mean;
                r_res.zero_seen <= r_zero;
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        o_div_start = 1'b0;
        o_div_rem0  = DW'(w_nmag >> FLD_W);
        o_div_low   = {w_nmag[FLD_W-1:0], {(QUO_W-FLD_W){1'b0}}};
        o_div_den   = r_den;
        case (r_state)
            ST_IDLE:  if (i_go) n_state = ST_READ;
            ST_READ:  n_state = ST_NP;
            ST_NP:    n_state = ST_RSUB;
            ST_RSUB:  n_state = ST_MAG;
            ST_MAG: begin
                if (!w_is_zero) begin
                    n_state = ST_MAC;
                end else begin
                    n_state = w_last_idx ? ST_FDIV : ST_READ;
                end
            end
            ST_MAC:   if (w_last_step) n_state = ST_DRAIN;
            ST_DRAIN: n_state = ST_DIVGO;
            ST_DIVGO: begin
                o_div_start = 1'b1;
                n_state     = ST_DIVW;
            end
            ST_DIVW:  if (i_div_done) n_state = ST_ACC;
            ST_ACC:   n_state = w_last_idx ? ST_FDIV : ST_READ;
            ST_FDIV: begin
                o_div_start = 1'b1;
                o_div_rem0  = '0;
                o_div_low   = w_ang_abs;
                o_div_den   = DW'(i_count);
                n_state     = ST_FWAIT;
            end
            ST_FWAIT: if (i_div_done) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_idx  <= '0;
                r_zero <= 1'b0;
                r_ang  <= '0;
            end
            ST_NP: begin
                for (int j = 0; j < 4; j++) begin
                    r_np[j] <= w_n * w_fld[j];
                end
            end
            ST_RSUB: begin
                for (int j = 0; j < 4; j++) begin
                    r_r[j] <= r_np[j] - RW'(i_sum[j]);
                end
            end
            ST_MAG: begin
                for (int j = 0; j < 4; j++) begin
                    r_mag[j] <= w_abs[j][MW-1:0];
                    r_neg[j] <= r_r[j][RW-1];
                end
                r_pair <= '0;
                r_k    <= '0;
                if (w_is_zero) begin
                    r_zero <= 1'b1;
                    r_idx  <= r_idx + 1'b1;
                end
            end
            ST_MAC: begin
                r_prod     <= w_a * w_chunk;
                r_prod_k   <= r_k;
                r_prod_num <= w_num_sel;
                r_prod_sub <= w_sub_sel;
                if (r_k == KW'(NCH - 1)) begin
                    r_k    <= '0;
                    r_pair <= r_pair + 1'b1;
                end else begin
                    r_k <= r_k + 1'b1;
                end
            end
            ST_ACC: begin
                r_ang <= w_ang_next;
                r_idx <= r_idx + 1'b1;
            end
            default: begin
            end
        endcase
    end

    // accumulate partial products in the cycle after the multiplier registers them
    always_ff @(posedge i_clk) begin
        if (r_state == ST_MAG) begin
            r_den <= '0;
            r_num <= '0;
        end else if (r_prod_v) begin
            if (!r_prod_num) begin
                r_den <= r_den + w_shift[DW-1:0];
            end else if (r_prod_sub) begin
                r_num <= r_num - w_shift;
            end else begin
                r_num <= r_num + w_shift;
            end
        end
    end

    assign o_res = r_res;

endmodule

[bench/mean_angular_velocity_about_centroid_tb.sv]
`timescale 1ns / 1ps
module mean_angular_velocity_about_centroid_tb;
    import mavc_pkg::*;

    localparam int CAP        = MAX_DISKS_DEF;
    localparam int STALL_MAX  = 40000;
    localparam int DRAIN_CYC  = 200;
    localparam longint ACC_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint ACC_MIN = -ACC_MAX - 1;

    typedef struct {
        logic signed [ANG_W-1:0] angular;
        logic [USED_W-1:0]       used;
        logic                    overflow;
        logic                    zero_radius;
    } t_omega;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    start = 1'b0;
    logic signed [FLD_W-1:0] i_position_x = '0;
    logic signed [FLD_W-1:0] i_position_y = '0;
    logic signed [FLD_W-1:0] i_velocity_x = '0;
    logic signed [FLD_W-1:0] i_velocity_y = '0;
    logic                    i_last_disk = 1'b0;
    logic                    busy;
    logic                    o_valid;
    logic signed [ANG_W-1:0] o_angular_velocity;
    logic [USED_W-1:0]       o_disks_used;
    logic                    o_capacity_overflow;
    logic                    o_zero_radius_seen;

    mean_angular_velocity_about_centroid dut (.*);

    always #2 i_clk = ~i_clk;

    // disks of the set being loaded, as seen by the predictor
    longint set_px[$], set_py[$], set_vx[$], set_vy[$];
    longint sum_px, sum_py, sum_vx, sum_vy;
    logic   set_dropped;
    t_omega omega_q[$];

    int  errors = 0;
    int  disks_sent = 0;
    int  sets_sent = 0;
    int  sets_checked = 0;
    int  quiet_cycles = 0;
    bit  accepted_now;
    bit  no_idle = 0;

    function automatic t_omega predict_omega();
        t_omega res;
        longint n, r1, r2, v1, v2, acc, q, term;
        logic signed [127:0] a1, a2, b1, b2, num;
        logic [127:0] mag, den, quo;
        res.zero_radius = 1'b0;
        n = set_px.size();
        acc = 0;
        for (int i = 0; i < n; i++) begin
            r1 = n * set_px[i] - sum_px;
            r2 = n * set_py[i] - sum_py;
            v1 = n * set_vx[i] - sum_vx;
            v2 = n * set_vy[i] - sum_vy;
            if (r1 == 0 && r2 == 0) begin
                res.zero_radius = 1'b1;
                continue;
            end
            a1 = r1; a2 = r2; b1 = v1; b2 = v2;
            num = a1 * b2 - a2 * b1;
            den = a1 * a1 + a2 * a2;
            mag = num[127] ? -num : num;
            mag = mag << 16;
            quo = mag / den;
            if (num[127])
                term = (quo > 128'h8000_0000_0000) ? ACC_MIN : -longint'(quo[63:0]);
            else
                term = (quo > 128'h7FFF_FFFF_FFFF) ? ACC_MAX : longint'(quo[63:0]);
            acc += term;
            if (acc > ACC_MAX) acc = ACC_MAX;
            if (acc < ACC_MIN) acc = ACC_MIN;
        end
        q = (n > 0) ? acc / n : 0;
        if (q > 64'sh7FFF_FFFF) q = 64'sh7FFF_FFFF;
        if (q < -64'sh8000_0000) q = -64'sh8000_0000;
        res.angular  = q[31:0];
        res.used     = n[USED_W-1:0];
        res.overflow = set_dropped;
        return res;
    endfunction

    task automatic clear_set();
        set_px.delete(); set_py.delete(); set_vx.delete(); set_vy.delete();
        sum_px = 0; sum_py = 0; sum_vx = 0; sum_vy = 0;
        set_dropped = 1'b0;
    endtask

    // drive one disk request and hold it until accepted
    task automatic send_disk(input logic [31:0] px, input logic [31:0] py,
                             input logic [31:0] vx, input logic [31:0] vy,
                             input logic last);
        int gap;
        start        <= 1'b1;
        i_position_x <= px;
        i_position_y <= py;
        i_velocity_x <= vx;
        i_velocity_y <= vy;
        i_last_disk  <= last;
        do @(posedge i_clk); while (busy);
        disks_sent++;
        if (set_px.size() < CAP) begin
            set_px.push_back(longint'(signed'(px)));
            set_py.push_back(longint'(signed'(py)));
            set_vx.push_back(longint'(signed'(vx)));
            set_vy.push_back(longint'(signed'(vy)));
            sum_px += longint'(signed'(px));
            sum_py += longint'(signed'(py));
            sum_vx += longint'(signed'(vx));
            sum_vy += longint'(signed'(vy));
        end else begin
            set_dropped = 1'b1;
        end
        if (last) begin
            omega_q.push_back(predict_omega());
            sets_sent++;
            clear_set();
        end
        if (!no_idle && $urandom_range(99) < 29) begin
            gap = $urandom_range(6, 1);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic logic [31:0] rand_field();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2, 3: return $urandom();
            default: return $urandom_range(32'h0004_0000) - 32'h0002_0000;
        endcase
    endfunction

    task automatic send_random_set(input int count);
        for (int i = 0; i < count; i++)
            send_disk(rand_field(), rand_field(), rand_field(), rand_field(),
                      i == count - 1);
    endtask

    task automatic test_lone_disk();
        send_disk(32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, 32'h7FFF_FFFF, 1'b1);
    endtask

    task automatic test_extremes();
        send_disk(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        send_disk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
        // opposite orbits: tiny radius, huge velocity drives term saturation
        send_disk(32'h0000_0001, 32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF, 1'b0);
        send_disk(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 1'b1);
        send_disk(32'h0000_0001, 32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 1'b0);
        send_disk(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF, 1'b1);
    endtask

    task automatic test_centroid();
        // middle disk sits exactly on the centroid
        send_disk(32'hFFFE_0000, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_0000, 1'b0);
        send_disk(32'h0000_0000, 32'h0000_0000, 32'h1234_5678, 32'h0000_0000, 1'b0);
        send_disk(32'h0002_0000, 32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 1'b1);
        // all disks coincide
        send_disk(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h0000_0002, 1'b0);
        send_disk(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0003, 1'b1);
    endtask

    task automatic test_capacity();
        // full store, then drops, closing on a dropped disk
        send_random_set(CAP + 3);
        // exactly full
        send_random_set(CAP);
    endtask

    task automatic test_random();
        int sz;
        no_idle = 1;
        repeat (15) send_random_set($urandom_range(6, 1));
        no_idle = 0;
        while (disks_sent < 500) begin
            sz = ($urandom_range(19) == 0) ? $urandom_range(CAP + 4, 30)
                                           : $urandom_range(8, 1);
            send_random_set(sz);
        end
        start <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (omega_q.size() == 0) begin
                $error("result with no set pending: angular_velocity %0d",
                       o_angular_velocity);
                errors++;
            end else begin
                t_omega e;
                e = omega_q.pop_front();
                sets_checked++;
                if (o_angular_velocity !== e.angular) begin
                    $error("angular_velocity: expected %0d, got %0d",
                           e.angular, o_angular_velocity);
                    errors++;
                end
                if (o_disks_used !== e.used) begin
                    $error("disks_used: expected %0d, got %0d", e.used, o_disks_used);
                    errors++;
                end
                if (o_capacity_overflow !== e.overflow) begin
                    $error("capacity_overflow: expected %0b, got %0b",
                           e.overflow, o_capacity_overflow);
                    errors++;
                end
                if (o_zero_radius_seen !== e.zero_radius) begin
                    $error("zero_radius_seen: expected %0b, got %0b",
                           e.zero_radius, o_zero_radius_seen);
                    errors++;
                end
            end
        end
    end

    // watchdog: cycles with neither a request taken nor a result seen
    always @(posedge i_clk) begin
        accepted_now = start && !busy;
        if (!i_rst_n || accepted_now || o_valid)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_MAX) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        clear_set();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_lone_disk();
        test_extremes();
        test_centroid();
        test_capacity();
        test_random();
        while (omega_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
        $display("Covered %0d disks in %0d sets, %0d results checked,", disks_sent,
                 sets_sent, sets_checked);
        $display("including centroid, saturation and over-capacity sets.");
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[mean_angular_velocity_about_centroid.f]
rtl/mavc_pkg.sv
rtl/mavc_store.sv
rtl/mavc_div.sv
rtl/mavc_core.sv
rtl/mean_angular_velocity_about_centroid.sv
bench/mean_angular_velocity_about_centroid_tb.sv
